// ===== src/khct_pkg.sv =====
// khct_pkg: shared types and constants for the k-mer hit chaining table
// no dependencies
package khct_pkg;

  localparam int MAX_PATHS = 32;
  localparam int POS_BITS  = 20;
  localparam int IDX_BITS  = $clog2(MAX_PATHS);
  localparam int CNT_BITS  = $clog2(MAX_PATHS + 1);
  localparam int RATE_BITS = 10;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [RATE_BITS-1:0] rate_t;

  // input actions
  localparam logic [1:0] ACT_HIT   = 2'd0;
  localparam logic [1:0] ACT_DUMP  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // result status codes
  localparam logic [3:0] ST_TRIVIAL = 4'd0;
  localparam logic [3:0] ST_SHORT   = 4'd1;
  localparam logic [3:0] ST_CLOSE   = 4'd2;
  localparam logic [3:0] ST_FAR     = 4'd3;
  localparam logic [3:0] ST_BOTH    = 4'd4;
  localparam logic [3:0] ST_NEW     = 4'd5;
  localparam logic [3:0] ST_NONE    = 4'd6;
  localparam logic [3:0] ST_FULL    = 4'd7;
  localparam logic [3:0] ST_PATH    = 4'd8;
  localparam logic [3:0] ST_EMPTY   = 4'd9;
  localparam logic [3:0] ST_CLEARED = 4'd10;

  // config register indexes
  localparam logic [2:0] REG_MIN_OVL   = 3'd0;
  localparam logic [2:0] REG_MAX_JUMP  = 3'd1;
  localparam logic [2:0] REG_END_LIM   = 3'd2;
  localparam logic [2:0] REG_CLOSE     = 3'd3;
  localparam logic [2:0] REG_FAR       = 3'd4;
  localparam logic [2:0] REG_DIV       = 3'd5;
  localparam logic [2:0] REG_MAX_OVH   = 3'd6;
  localparam logic [2:0] REG_CHECK_OVH = 3'd7;

  // one accepted request as handed from front to back
  typedef struct packed {
    logic [1:0] action;
    pos_t       cur_pos;
    pos_t       ext_pos;
    pos_t       cur_len;
    pos_t       ext_len;
    logic       same_read;
    logic       ext_is_self_rc;
  } req_t;

  // one result item
  typedef struct packed {
    logic [3:0] status;
    logic [5:0] path_count;
    pos_t       cur_begin;
    pos_t       cur_end;
    pos_t       ext_begin;
    pos_t       ext_end;
    logic       passes_test;
    logic       last;
  } res_t;

  // configuration snapshot
  typedef struct packed {
    pos_t  min_overlap;
    pos_t  max_jump;
    pos_t  jump_end_limit;
    rate_t close_jump_rate;
    rate_t far_jump_rate;
    rate_t divergence_rate;
    pos_t  max_overhang;
    logic  check_overhang;
  } cfg_t;

endpackage

// ===== src/khct_front.sv =====
// khct_front: request intake queue between the ports and the table engine
// depends on khct_pkg
module khct_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  khct_pkg::req_t  in_req,
  output logic            req_valid,
  input  logic            req_take,
  output khct_pkg::req_t  req
);

  localparam int QD = 2;

  khct_pkg::req_t mem [QD];
  logic           wptr, rptr;
  logic [1:0]     count;

  assign full      = (count == 2'(QD));
  assign req_valid = (count != 2'd0);
  assign req       = mem[rptr];

  // two-entry request queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (req_take && req_valid) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push && !full) - 2'(req_take && req_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= in_req;
    end
  end

endmodule

// ===== src/khct_engine.sv =====
// khct_engine: path table with scan, append, compaction and dump sequencer
// depends on khct_pkg
module khct_engine (
  input  logic            clk,
  input  logic            rst,
  input  khct_pkg::cfg_t  cfg,
  input  logic            req_valid,
  output logic            req_take,
  input  khct_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_ready,
  output khct_pkg::res_t  res
);

  localparam int PB = khct_pkg::POS_BITS;
  localparam int MP = khct_pkg::MAX_PATHS;
  localparam int RATE_W = khct_pkg::RATE_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_APPLY = 7'b0000100,
    S_PACK  = 7'b0001000,
    S_DUMP  = 7'b0010000,
    S_DCHK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // path entry
  typedef struct packed {
    khct_pkg::pos_t bq;
    khct_pkg::pos_t eq;
    khct_pkg::pos_t bo;
    khct_pkg::pos_t eo;
    khct_pkg::pos_t lq;
    khct_pkg::pos_t lo;
    logic           src;
  } path_t;

  state_t          state;
  path_t           tbl [MP];
  logic [MP-1:0]   dead;
  khct_pkg::cnt_t  total, n;
  khct_pkg::cnt_t  k;
  khct_pkg::req_t  cur;
  logic            ext_c, ext_f, dropped, made_new;
  khct_pkg::idx_t  ci, fi;
  khct_pkg::pos_t  best_c, best_f;
  khct_pkg::pos_t  tol_c, tol_f;
  logic [3:0]      out_status;
  logic            out_last;
  path_t           dp;
  logic            dpass;
  logic [1:0]      step;
  logic            out_full;
  logic            out_load;
  khct_pkg::res_t  out_reg;

  // tolerance division unit (restoring, one bit per cycle)
  logic [PB-1:0]   dv_q, dv_r;
  logic [4:0]      dv_i;
  logic            dv_sel;
  logic [PB:0]     dv_trial;
  khct_pkg::rate_t dv_den;

  assign req_take  = (state == S_IDLE) && req_valid;
  assign res_valid = out_full;
  assign res       = out_reg;

  // output register loads in these states when it is free or being popped
  assign out_load  = (!out_full || res_ready) &&
                     ((state == S_OUT) || (state == S_DCHK && step != 2'd0));

  // scan element
  path_t           se;
  logic signed [PB+1:0] dq, de, dd, add;
  logic            in_q, in_e, is_close, is_far;
  khct_pkg::pos_t  jl;
  logic            jl_pos;
  always_comb begin
    se   = tbl[k[khct_pkg::IDX_BITS-1:0]];
    dq   = $signed({2'b0, cur.cur_pos}) - $signed({2'b0, se.eq});
    de   = $signed({2'b0, cur.ext_pos}) - $signed({2'b0, se.eo});
    dd   = dq - de;
    add  = (dd < 0) ? -dd : dd;
    in_q = (dq > 0) && (dq < $signed({2'b0, cfg.max_jump}));
    in_e = (de > 0) && (de < $signed({2'b0, cfg.max_jump}));
    is_close = !(dq > $signed({2'b0, cfg.jump_end_limit})) && in_q && in_e
               && (add < $signed({2'b0, tol_c}));
    is_far   = !(dq > $signed({2'b0, cfg.jump_end_limit})) && in_q && in_e
               && !is_close && (add < $signed({2'b0, tol_f}));
    jl_pos = cur.cur_pos > se.bq;
    jl     = cur.cur_pos - se.bq;
  end

  // good start check
  logic signed [PB+1:0] gs_e, gs_c;
  logic good;
  khct_pkg::pos_t mn;
  always_comb begin
    mn   = (cur.cur_pos < cur.ext_pos) ? cur.cur_pos : cur.ext_pos;
    gs_e = $signed({2'b0, cur.ext_len}) - $signed({2'b0, cfg.min_overlap});
    gs_c = $signed({2'b0, cur.cur_len}) - $signed({2'b0, cfg.min_overlap});
    good = !(cfg.check_overhang && mn > cfg.max_overhang)
           && !($signed({2'b0, cur.ext_pos}) > gs_e)
           && !($signed({2'b0, cur.cur_pos}) > gs_c);
  end

  // overlap test, two registered steps
  logic signed [PB+1:0] rq, ro, drr, adr, tq, to;
  logic [PB+RATE_W:0]   lhs_a;
  logic [PB+RATE_W+1:0] lhs;
  logic [PB+1:0]        rsum;
  logic                 p1_ok, chk_ok;
  khct_pkg::rate_t      drate;
  khct_pkg::pos_t       mb;
  always_comb begin
    rq    = $signed({2'b0, dp.eq}) - $signed({2'b0, dp.bq});
    ro    = $signed({2'b0, dp.eo}) - $signed({2'b0, dp.bo});
    drr   = rq - ro;
    adr   = (drr < 0) ? -drr : drr;
    drate = (cfg.divergence_rate == '0) ? khct_pkg::rate_t'(1) : cfg.divergence_rate;
    lhs_a = (PB+RATE_W+1)'(adr[PB:0]) * (PB+RATE_W+1)'(drate);
    lhs   = {lhs_a, 1'b0};
    rsum  = (PB+2)'(rq + ro);
    p1_ok = !(rq < $signed({2'b0, cfg.min_overlap}))
            && !(ro < $signed({2'b0, cfg.min_overlap}));
    mb    = (dp.bq < dp.bo) ? dp.bq : dp.bo;
    tq    = $signed({2'b0, dp.lq}) - $signed({2'b0, dp.eq});
    to    = $signed({2'b0, dp.lo}) - $signed({2'b0, dp.eo});
    chk_ok = !(cfg.check_overhang && !dp.src &&
               ((mb > cfg.max_overhang) ||
                (((tq < to) ? tq : to) > $signed({2'b0, cfg.max_overhang}))));
  end

  always_comb begin
    dv_den   = dv_sel ? cfg.far_jump_rate : cfg.close_jump_rate;
    if (dv_den == '0) begin
      dv_den = khct_pkg::rate_t'(1);
    end
    dv_trial = {dv_r, cfg.max_jump[5'(PB-1) - dv_i]} - (PB+1)'(dv_den);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      total    <= '0;
      out_full <= 1'b0;
    end else begin
      if (out_full && res_ready && !out_load) begin
        out_full <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur      <= req;
            out_last <= 1'b1;
            case (req.action)
              khct_pkg::ACT_HIT: begin
                if (req.same_read && req.ext_pos == req.cur_pos) begin
                  out_status <= khct_pkg::ST_TRIVIAL;
                  state      <= S_OUT;
                end else if (req.ext_len < cfg.min_overlap) begin
                  out_status <= khct_pkg::ST_SHORT;
                  state      <= S_OUT;
                end else begin
                  k <= '0; n <= total; dead <= '0;
                  ext_c <= 1'b0; ext_f <= 1'b0; dropped <= 1'b0; made_new <= 1'b0;
                  best_c <= '0; best_f <= '0; ci <= '0; fi <= '0; tol_f <= '0;
                  dv_r <= '0; dv_q <= '0; dv_i <= '0; dv_sel <= 1'b0;
                  state <= S_SCAN;
                end
              end
              khct_pkg::ACT_DUMP: begin
                k <= '0;
                if (total == '0) begin
                  out_status <= khct_pkg::ST_EMPTY;
                  state      <= S_OUT;
                end else begin
                  step  <= 2'd0;
                  state <= S_DUMP;
                end
              end
              khct_pkg::ACT_CLEAR: begin
                total      <= '0;
                out_status <= khct_pkg::ST_CLEARED;
                state      <= S_OUT;
              end
              default: begin
                out_status <= khct_pkg::ST_NONE;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (dv_i != 5'(PB) || !dv_sel) begin
            // tolerance divisions first (close then far)
            if (dv_i == 5'(PB)) begin
              tol_c <= dv_q; dv_sel <= 1'b1; dv_i <= '0; dv_r <= '0;
            end else begin
              if (!dv_trial[PB]) begin
                dv_r <= dv_trial[PB-1:0]; dv_q <= {dv_q[PB-2:0], 1'b1};
              end else begin
                dv_r <= {dv_r[PB-2:0], cfg.max_jump[5'(PB-1) - dv_i]};
                dv_q <= {dv_q[PB-2:0], 1'b0};
              end
              dv_i <= dv_i + 5'd1;
            end
          end else if (k == n) begin
            tol_f <= dv_q;
            state <= S_APPLY;
          end else begin
            if (k == '0 && tol_f != dv_q) begin
              tol_f <= dv_q;
            end else begin
              if (is_close) begin
                dead[k[khct_pkg::IDX_BITS-1:0]] <= 1'b1;
                if (jl_pos && jl > best_c) begin
                  ext_c <= 1'b1; ci <= k[khct_pkg::IDX_BITS-1:0]; best_c <= jl;
                end
              end else if (is_far) begin
                if (jl_pos && jl > best_f) begin
                  ext_f <= 1'b1; fi <= k[khct_pkg::IDX_BITS-1:0]; best_f <= jl;
                end
              end
              k <= k + 1'b1;
            end
          end
        end
        S_APPLY: begin
          if (ext_c) begin
            dead[ci]   <= 1'b0;
            tbl[ci].eq <= cur.cur_pos;
            tbl[ci].eo <= cur.ext_pos;
          end
          if (ext_f) begin
            if (n < khct_pkg::cnt_t'(MP)) begin
              tbl[n[khct_pkg::IDX_BITS-1:0]] <= '{bq: tbl[fi].bq, eq: cur.cur_pos,
                bo: tbl[fi].bo, eo: cur.ext_pos, lq: tbl[fi].lq, lo: tbl[fi].lo,
                src: tbl[fi].src};
              n <= n + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
          if (!ext_c && !ext_f && (good || cur.ext_is_self_rc)) begin
            if (n < khct_pkg::cnt_t'(MP)) begin
              tbl[n[khct_pkg::IDX_BITS-1:0]] <= '{bq: cur.cur_pos, eq: cur.cur_pos,
                bo: cur.ext_pos, eo: cur.ext_pos, lq: cur.cur_len, lo: cur.ext_len,
                src: cur.ext_is_self_rc};
              n <= n + 1'b1;
              made_new <= 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
          k     <= n + khct_pkg::cnt_t'(ext_f && n < khct_pkg::cnt_t'(MP));
          state <= S_PACK;
        end
        S_PACK: begin
          // swap-with-last from the top, one slot per cycle
          if (k == '0) begin
            total <= n;
            if (dropped)            out_status <= khct_pkg::ST_FULL;
            else if (ext_c && ext_f) out_status <= khct_pkg::ST_BOTH;
            else if (ext_c)         out_status <= khct_pkg::ST_CLOSE;
            else if (ext_f)         out_status <= khct_pkg::ST_FAR;
            else if (made_new)      out_status <= khct_pkg::ST_NEW;
            else                    out_status <= khct_pkg::ST_NONE;
            state <= S_OUT;
          end else begin
            if (dead[k[khct_pkg::IDX_BITS-1:0] - 1'b1]) begin
              tbl[k[khct_pkg::IDX_BITS-1:0] - 1'b1] <= tbl[n[khct_pkg::IDX_BITS-1:0] - 1'b1];
              dead[k[khct_pkg::IDX_BITS-1:0] - 1'b1] <= dead[n[khct_pkg::IDX_BITS-1:0] - 1'b1];
              n <= n - 1'b1;
            end
            k <= k - 1'b1;
          end
        end
        S_DUMP: begin
          if (!out_full || res_ready) begin
            dp    <= tbl[k[khct_pkg::IDX_BITS-1:0]];
            state <= S_DCHK;
          end
        end
        S_DCHK: begin
          dpass <= p1_ok && !(lhs > (PB+RATE_W+2)'(rsum)) && chk_ok;
          if (step == 2'd0) begin
            step <= 2'd1;
          end else if (!out_full || res_ready) begin
            step     <= 2'd0;
            out_full <= 1'b1;
            out_reg  <= '{status: khct_pkg::ST_PATH, path_count: 6'(total),
              cur_begin: dp.bq, cur_end: dp.eq, ext_begin: dp.bo, ext_end: dp.eo,
              passes_test: dpass, last: (k + 1'b1 == total)};
            if (k + 1'b1 == total) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_DUMP;
            end
          end
        end
        S_OUT: begin
          if (!out_full || res_ready) begin
            out_full <= 1'b1;
            out_reg  <= '{status: out_status, path_count: 6'(total), cur_begin: '0,
              cur_end: '0, ext_begin: '0, ext_end: '0, passes_test: 1'b0,
              last: out_last};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/kmer_hit_chaining_table.sv =====
// kmer_hit_chaining_table: top level, config registers, front queue and table engine
// depends on khct_pkg, khct_front, khct_engine
// a hit runs two tolerance divisions, then the table scan and compaction sweep;
// one request at a time in the engine, two queue ahead
// reset: synchronous, clears the table count, queue and registers to defaults
module kmer_hit_chaining_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [19:0] cur_pos,
  input  logic [19:0] ext_pos,
  input  logic [19:0] cur_len,
  input  logic [19:0] ext_len,
  input  logic        same_read,
  input  logic        ext_is_self_rc,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  status,
  output logic [5:0]  path_count,
  output logic [19:0] cur_begin,
  output logic [19:0] cur_end,
  output logic [19:0] ext_begin,
  output logic [19:0] ext_end,
  output logic        passes_test,
  output logic        last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  khct_pkg::cfg_t cfg;
  khct_pkg::req_t in_req, req;
  khct_pkg::res_t res;
  logic           req_valid, req_take, res_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{min_overlap: 20'd5000, max_jump: 20'd1500, jump_end_limit: 20'd1500,
        close_jump_rate: 10'd100, far_jump_rate: 10'd1, divergence_rate: 10'd5,
        max_overhang: 20'd1500, check_overhang: 1'b1};
    end else if (cfg_we) begin
      case (cfg_index)
        khct_pkg::REG_MIN_OVL:   cfg.min_overlap     <= cfg_data;
        khct_pkg::REG_MAX_JUMP:  cfg.max_jump        <= cfg_data;
        khct_pkg::REG_END_LIM:   cfg.jump_end_limit  <= cfg_data;
        khct_pkg::REG_CLOSE:     cfg.close_jump_rate <= cfg_data[9:0];
        khct_pkg::REG_FAR:       cfg.far_jump_rate   <= cfg_data[9:0];
        khct_pkg::REG_DIV:       cfg.divergence_rate <= cfg_data[9:0];
        khct_pkg::REG_MAX_OVH:   cfg.max_overhang    <= cfg_data;
        khct_pkg::REG_CHECK_OVH: cfg.check_overhang  <= cfg_data[0];
        default: cfg <= cfg;
      endcase
    end
  end

  assign in_req = '{action: action, cur_pos: cur_pos, ext_pos: ext_pos,
    cur_len: cur_len, ext_len: ext_len, same_read: same_read,
    ext_is_self_rc: ext_is_self_rc};

  khct_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_req(in_req),
    .req_valid(req_valid), .req_take(req_take), .req(req)
  );

  khct_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg), .req_valid(req_valid), .req_take(req_take),
    .req(req), .res_valid(res_valid), .res_ready(pop), .res(res)
  );

  assign empty       = !res_valid;
  assign status      = res.status;
  assign path_count  = res.path_count;
  assign cur_begin   = res.cur_begin;
  assign cur_end     = res.cur_end;
  assign ext_begin   = res.ext_begin;
  assign ext_end     = res.ext_end;
  assign passes_test = res.passes_test;
  assign last        = res.last;

  // path count never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> path_count <= 6'(khct_pkg::MAX_PATHS))
    else $error("path count out of range");

  // non-path results carry zero path fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != khct_pkg::ST_PATH) |-> (cur_begin == '0 && !passes_test))
    else $error("non-path result with path fields");

  // a held result stays until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status)))
    else $error("result dropped before pop");

endmodule
